// File: src/fsla_pkg.sv
// Shared constants and types for the fixed-slot free-list allocator.
// No dependencies; every other file in src/ except fsla_ram refers to this package by scope.
package fsla_pkg;

  // Pool geometry
  localparam int MAX_SLOTS = 256;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int LINK_W    = SLOT_W + 1;  // {valid, index}

  // Item commands
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_IGNORED   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic direct;   // finish item now: release or exhausted allocate
    logic rd_link;  // read the head slot's link
    logic pop;      // link data is back: pop the head
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic head_ok;  // free list is not empty
  } dp_stat_t;

endpackage

// File: src/fsla_in_if.sv
// Input item channel: valid/ready handshake with allocate/release payload.
// Depends on fsla_pkg for the slot width.
interface fsla_in_if;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [fsla_pkg::SLOT_W-1:0] slot;
  logic                      slot_is_null;

  modport source (output valid, command, slot, slot_is_null, input ready);
  modport sink   (input valid, command, slot, slot_is_null, output ready);
endinterface

// File: src/fsla_out_if.sv
// Result item channel: valid/ready handshake with grant, status and pool state.
// Depends on fsla_pkg for field widths.
interface fsla_out_if;
  logic                        valid;
  logic                        ready;
  logic [fsla_pkg::SLOT_W-1:0] granted_slot;
  logic [1:0]                  status;
  logic [fsla_pkg::CNT_W-1:0]  free_count;
  logic                        none_free;
  logic                        all_free;

  modport source (output valid, granted_slot, status, free_count, none_free, all_free,
                  input ready);
  modport sink   (input valid, granted_slot, status, free_count, none_free, all_free,
                  output ready);
endinterface

// File: src/fixed_slot_free_list_allocator_top.sv
// Allocate passes through the pop state after acceptance: the head slot's link is
// read from a registered-read RAM before the head can move, so the next item is
// accepted only once the pop state has returned to idle. Release, ignored release
// and exhausted allocate finish directly from idle. Results sit in an output
// register; a new item is taken while that register is empty or in the cycle it
// drains. A capacity write rebuilds the free list directly (per-slot written flags
// clear at once), so there is no clearing pass after reset or configuration.
//
// Top level of the fixed-slot free-list allocator.
// Depends on fsla_pkg, fsla_in_if, fsla_out_if, fsla_ctrl, fsla_dp, fsla_ram.
module fixed_slot_free_list_allocator_top (
  input  logic                       clk,
  input  logic                       rst_n,
  fsla_in_if.sink                    in_ch,
  fsla_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [fsla_pkg::CNT_W-1:0] cfg_data
);

  fsla_pkg::ctrl_cmd_t cmd;
  fsla_pkg::dp_stat_t  stat;

  // Sequencing
  fsla_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Free list state and results
  fsla_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_ch.command),
    .in_slot         (in_ch.slot),
    .in_slot_is_null (in_ch.slot_is_null),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .granted_slot    (out_ch.granted_slot),
    .status          (out_ch.status),
    .free_count      (out_ch.free_count),
    .none_free       (out_ch.none_free),
    .all_free        (out_ch.all_free)
  );

endmodule

// File: src/fsla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fsla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/fsla_ctrl.sv
// Allocator controller: accepts items, sequences the link read for allocate,
// and owns the result valid flag. Depends on fsla_pkg.
module fsla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_command,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fsla_pkg::dp_stat_t   stat,
  output fsla_pkg::ctrl_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;
  logic accept;

  // Result register is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_command == fsla_pkg::CMD_ALLOC && stat.head_ok) begin
            cmd.rd_link = 1'b1;
            state_nxt   = S_POP;
          end else begin
            cmd.direct    = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_POP: begin
        cmd.pop       = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result register was drained before the pop cycle loads it
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !out_valid_r)
    else $error("result register busy during pop");

  // The pop state is always followed by idle on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (state_r == S_IDLE))
    else $error("pop state did not return to idle");

  // A link read is always followed by a pop that posts a result
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_link |=> (cmd.pop && out_valid_nxt))
    else $error("link read not followed by pop");

endmodule

// File: src/fsla_dp.sv
// Allocator datapath: capacity, head, free count, link RAM, written flags and
// the result register. Depends on fsla_pkg and fsla_ram.
module fsla_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fsla_pkg::ctrl_cmd_t         cmd,
  output fsla_pkg::dp_stat_t          stat,
  input  logic                        in_command,
  input  logic [fsla_pkg::SLOT_W-1:0] in_slot,
  input  logic                        in_slot_is_null,
  input  logic                        cfg_we,
  input  logic [fsla_pkg::CNT_W-1:0]  cfg_data,
  output logic [fsla_pkg::SLOT_W-1:0] granted_slot,
  output logic [1:0]                  status,
  output logic [fsla_pkg::CNT_W-1:0]  free_count,
  output logic                        none_free,
  output logic                        all_free
);

  localparam int SW = fsla_pkg::SLOT_W;
  localparam int CW = fsla_pkg::CNT_W;
  localparam int LW = fsla_pkg::LINK_W;
  localparam int NS = fsla_pkg::MAX_SLOTS;

  // Pool state
  logic [CW-1:0] cap_r, cap_nxt;
  logic [SW-1:0] head_r, head_nxt;
  logic          head_ok_r, head_ok_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [NS-1:0] written_r, written_nxt;
  logic          link_wr_r;

  // Result register
  logic [SW-1:0] granted_r, granted_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [CW-1:0] fcount_r;
  logic          none_r, all_r;

  logic [CW-1:0] cap_clamped, cap_m1;
  logic          rel_ok;
  logic          push;
  logic [LW-1:0] link_rdata;
  logic [SW-1:0] link_idx;
  logic          link_ok;
  logic [CW-1:0] count_inc, count_dec;
  logic          load_res;

  assign stat.head_ok = head_ok_r;

  // Rebuild values for a capacity write
  assign cap_clamped = (cfg_data > CW'(NS)) ? CW'(NS) : cfg_data;
  assign cap_m1      = cap_clamped - CW'(1);

  // Release check: named, in range
  assign rel_ok = (in_command == fsla_pkg::CMD_RELEASE) && !in_slot_is_null &&
                  ({1'b0, in_slot} < cap_r);
  assign push   = cmd.direct && rel_ok;

  // Link memory: pushed slot links to the old head
  fsla_ram #(.WIDTH(LW), .DEPTH(NS)) u_link_ram (
    .clk   (clk),
    .we    (push),
    .waddr (in_slot),
    .wdata ({head_ok_r, head_r}),
    .re    (cmd.rd_link),
    .raddr (head_r),
    .rdata (link_rdata)
  );

  // Unwritten entries read as the set-up chain: slot i links to i-1
  assign link_idx = link_wr_r ? link_rdata[SW-1:0] : (head_r - SW'(1));
  assign link_ok  = link_wr_r ? link_rdata[SW] :
                    ((head_r != '0) && ({1'b0, head_r} < cap_r));

  // Saturating count steps
  assign count_inc = (count_r < cap_r) ? (count_r + CW'(1)) : count_r;
  assign count_dec = (count_r != '0) ? (count_r - CW'(1)) : count_r;

  assign load_res = cmd.direct || cmd.pop;

  // Next pool state and result
  always_comb begin
    cap_nxt     = cap_r;
    head_nxt    = head_r;
    head_ok_nxt = head_ok_r;
    count_nxt   = count_r;
    written_nxt = written_r;
    granted_nxt = '0;
    status_nxt  = fsla_pkg::ST_OK;
    if (cfg_we) begin
      cap_nxt     = cap_clamped;
      head_nxt    = cap_m1[SW-1:0];
      head_ok_nxt = (cap_clamped != '0);
      count_nxt   = cap_clamped;
      written_nxt = '0;
    end else if (cmd.pop) begin
      granted_nxt = head_r;
      head_nxt    = link_idx;
      head_ok_nxt = link_ok;
      count_nxt   = count_dec;
    end else if (cmd.direct) begin
      if (rel_ok) begin
        head_nxt             = in_slot;
        head_ok_nxt          = 1'b1;
        count_nxt            = count_inc;
        written_nxt[in_slot] = 1'b1;
      end else if (in_command == fsla_pkg::CMD_ALLOC) begin
        status_nxt = fsla_pkg::ST_EXHAUSTED;
      end else begin
        status_nxt = fsla_pkg::ST_IGNORED;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CW'(NS);
      head_r    <= SW'(NS - 1);
      head_ok_r <= 1'b1;
      count_r   <= CW'(NS);
      written_r <= '0;
    end else begin
      cap_r     <= cap_nxt;
      head_r    <= head_nxt;
      head_ok_r <= head_ok_nxt;
      count_r   <= count_nxt;
      written_r <= written_nxt;
    end
  end

  // Payload: written flag travels with the link read; result fields
  always_ff @(posedge clk) begin
    if (cmd.rd_link) begin
      link_wr_r <= written_r[head_r];
    end
    if (load_res) begin
      granted_r <= granted_nxt;
      status_r  <= status_nxt;
      fcount_r  <= count_nxt;
      none_r    <= (count_nxt == '0);
      all_r     <= (count_nxt == cap_r);
    end
  end

  assign granted_slot = granted_r;
  assign status       = status_r;
  assign free_count   = fcount_r;
  assign none_free    = none_r;
  assign all_free     = all_r;

  // Free count never exceeds capacity
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cap_r)
    else $error("free count above capacity");

  // A valid head always names a slot inside the pool
  assert property (@(posedge clk) disable iff (!rst_n)
    head_ok_r |-> ({1'b0, head_r} < cap_r))
    else $error("head outside pool");

  // A pop hands out the head that was read
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (granted_r == $past(head_r) && status_r == fsla_pkg::ST_OK))
    else $error("pop result does not match head");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for fixed_slot_free_list_allocator_top: directed and random
// allocate/release items with random idling on both channels, checked by a scoreboard.
// Depends on fsla_pkg, fsla_in_if, fsla_out_if and the allocator RTL.

typedef struct packed {
  logic [fsla_pkg::SLOT_W-1:0] granted_slot;
  logic [1:0]                  status;
  logic [fsla_pkg::CNT_W-1:0]  free_count;
  logic                        none_free;
  logic                        all_free;
} pool_result_t;

// Scoreboard: tracks the free list and predicts one result per accepted item
class slot_pool_tracker;
  logic [fsla_pkg::SLOT_W-1:0] link_to [fsla_pkg::MAX_SLOTS];
  bit                          link_valid [fsla_pkg::MAX_SLOTS];
  logic [fsla_pkg::SLOT_W-1:0] head;
  bit                          head_valid;
  int unsigned                 free_n;
  int unsigned                 capacity;
  pool_result_t                pending_results[$];
  int unsigned                 held[$];  // slots granted and not yet returned
  int unsigned errors, n_items, n_granted, n_exhausted, n_ignored, n_returned, n_settings;

  function new();
    rebuild(fsla_pkg::MAX_SLOTS);
  endfunction

  // Chain the pool so the highest slot goes out first
  function void rebuild(int unsigned requested);
    capacity = (requested > fsla_pkg::MAX_SLOTS) ? fsla_pkg::MAX_SLOTS : requested;
    for (int i = 0; i < fsla_pkg::MAX_SLOTS; i++) begin
      link_valid[i] = (i > 0) && (i < capacity);
      link_to[i]    = link_valid[i] ? fsla_pkg::SLOT_W'(i - 1) : '0;
    end
    head_valid = capacity > 0;
    head       = head_valid ? fsla_pkg::SLOT_W'(capacity - 1) : '0;
    free_n     = capacity;
    held.delete();
    n_settings++;
  endfunction

  function void take_item(logic cmd, logic [fsla_pkg::SLOT_W-1:0] s, logic is_null);
    pool_result_t r;
    int unsigned  h;
    r = '0;
    r.status = fsla_pkg::ST_OK;
    n_items++;
    if (cmd == fsla_pkg::CMD_ALLOC) begin
      if (!head_valid) begin
        r.status = fsla_pkg::ST_EXHAUSTED;
        n_exhausted++;
      end else begin
        h = head;
        r.granted_slot = fsla_pkg::SLOT_W'(h);
        head_valid = link_valid[h];
        head       = link_to[h];
        if (free_n > 0) free_n--;
        held.push_back(h);
        n_granted++;
      end
    end else if (is_null || s >= capacity) begin
      r.status = fsla_pkg::ST_IGNORED;
      n_ignored++;
    end else begin
      // push; a double release is taken as is, count saturates
      link_to[s]    = head;
      link_valid[s] = head_valid;
      head          = s;
      head_valid    = 1'b1;
      if (free_n < capacity) free_n++;
      for (int k = 0; k < held.size(); k++) begin
        if (held[k] == s) begin
          held.delete(k);
          break;
        end
      end
      n_returned++;
    end
    r.free_count = fsla_pkg::CNT_W'(free_n);
    r.none_free  = (free_n == 0);
    r.all_free   = (free_n == capacity);
    pending_results.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(pool_result_t got);
    pool_result_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected, actual %p", $time, got);
      return;
    end
    want = pending_results.pop_front();
    compare_field("granted_slot", 32'(want.granted_slot), 32'(got.granted_slot));
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("free_count", 32'(want.free_count), 32'(got.free_count));
    compare_field("none_free", 32'(want.none_free), 32'(got.none_free));
    compare_field("all_free", 32'(want.all_free), 32'(got.all_free));
  endfunction
endclass

module testbench;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 4;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [fsla_pkg::CNT_W-1:0] cfg_data;

  fsla_in_if  in_ch ();
  fsla_out_if out_ch ();

  fixed_slot_free_list_allocator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  slot_pool_tracker book;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;
  int unsigned hold_granted;
  int unsigned hold_left;
  int unsigned cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               book.pending_results.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result side ready: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left == 0 && hold_requests != hold_granted) begin
      hold_granted = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_result({out_ch.granted_slot, out_ch.status, out_ch.free_count,
                         out_ch.none_free, out_ch.all_free});
  end

  // Offer one item; called and returns at a falling edge
  task automatic send_item(input logic cmd, input logic [fsla_pkg::SLOT_W-1:0] s,
                           input logic is_null);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.slot         <= s;
    in_ch.slot_is_null <= is_null;
    do @(posedge clk); while (!in_ch.ready);
    book.take_item(cmd, s, is_null);
    @(negedge clk);
  endtask

  // Stop offering and wait until every result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (book.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(input int unsigned cap);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= cap[fsla_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    book.rebuild(cap);
  endtask

  // Random items: mostly fill-then-drain runs that return granted slots, some noise
  task automatic random_items(input int n);
    logic                        cmd;
    logic [fsla_pkg::SLOT_W-1:0] s;
    logic                        is_null;
    bit                          filling;
    int unsigned                 pick;
    filling = 1'b1;
    repeat (n) begin
      if (!book.head_valid) filling = 1'b0;
      else if (book.held.size() == 0) filling = 1'b1;
      s = fsla_pkg::SLOT_W'($urandom_range(255));
      if ($urandom_range(99) < 80) begin
        is_null = 1'b0;
        cmd     = fsla_pkg::CMD_ALLOC;
        if (book.held.size() != 0 && $urandom_range(99) < (filling ? 10 : 90)) begin
          pick = $urandom_range(book.held.size() - 1);
          cmd  = fsla_pkg::CMD_RELEASE;
          s    = fsla_pkg::SLOT_W'(book.held[pick]);
        end
      end else begin
        // noise: null, out-of-range and double releases, allocates with junk fields
        cmd     = 1'($urandom_range(1));
        is_null = ($urandom_range(3) == 0);
        if ($urandom_range(1) && book.capacity > 0)
          s = fsla_pkg::SLOT_W'($urandom_range(book.capacity - 1));
      end
      send_item(cmd, s, is_null);
    end
  endtask

  initial begin
    int unsigned caps [16];
    int unsigned cap;
    book = new();
    book.n_settings = 0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.command      = fsla_pkg::CMD_ALLOC;
    in_ch.slot         = '0;
    in_ch.slot_is_null = 1'b0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    hold_requests      = 0;
    hold_granted       = 0;
    hold_left          = 0;
    cycles             = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: full pool after reset, saturation on repeated release
    send_item(fsla_pkg::CMD_ALLOC, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_ALLOC, 8'hFF, 1'b1);
    send_item(fsla_pkg::CMD_RELEASE, 8'd255, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd0, 1'b1);
    send_item(fsla_pkg::CMD_RELEASE, 8'd255, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd255, 1'b0);
    // Small pool: out of range, exhaustion, back to all free
    set_capacity(4);
    send_item(fsla_pkg::CMD_RELEASE, 8'd4, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd255, 1'b0);
    repeat (5) send_item(fsla_pkg::CMD_ALLOC, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd3, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd2, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd1, 1'b0);
    // Empty pool
    set_capacity(0);
    send_item(fsla_pkg::CMD_ALLOC, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd0, 1'b1);
    // Oversized write clamps to the full pool
    set_capacity(300);
    send_item(fsla_pkg::CMD_ALLOC, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd255, 1'b0);
    // Single slot
    set_capacity(1);
    send_item(fsla_pkg::CMD_ALLOC, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_ALLOC, 8'd0, 1'b0);
    send_item(fsla_pkg::CMD_RELEASE, 8'd0, 1'b0);

    // Random phases over a range of pool sizes and idling regimes
    caps = '{1, 256, 9, 0, 4, 2, 300, 17, 0, 3, 256, 6, 511, 1, 64, 8};
    caps[8] = $urandom_range(255, 1);
    for (int p = 0; p < 16; p++) begin
      cap = caps[p];
      set_capacity(cap);
      if (p < 5) begin
        send_idle_pct = 9;
        recv_idle_pct = 46;
      end else if (p < 10) begin
        send_idle_pct = 46;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 10) hold_requests++;  // long result-side hold while items keep coming
      random_items(cap == 256 ? 450 : (cap > 256 ? 60 : 45));
    end

    settle();
    $display("covered %0d items over %0d pool settings: %0d grants, %0d exhausted,",
             book.n_items, book.n_settings, book.n_granted, book.n_exhausted);
    $display("%0d returns, %0d ignored releases, %0d long result-side holds",
             book.n_returned, book.n_ignored, hold_granted);
    if (book.errors == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end
endmodule
